// ===== hw/rtl/c8ie_pkg.sv =====
// c8ie_pkg: shared types, constants and the hex font for the chip8 executor
// no dependencies

package c8ie_pkg;

	localparam int MEM_AW       = 12;
	localparam int MEMORY_DEPTH = 1 << MEM_AW;
	localparam int SP_W         = 4;
	localparam int STACK_DEPTH  = 1 << SP_W;
	localparam int FONT_BYTES   = 80;

	localparam logic [11:0] START_RESET = 12'h200;
	localparam logic [7:0]  TDIV_RESET  = 8'd9;

	localparam logic CFG_START = 1'b0;
	localparam logic CFG_TDIV  = 1'b1;

	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_EXEC = 2'd1,
		ACT_READ = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_LOAD, ST_RADDR, ST_RDATA, ST_FETCH0, ST_FETCH1,
		ST_FETCH2, ST_EXEC, ST_FLAG, ST_LOOP, ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		DP_IDLE, DP_CLEAR, DP_LOAD, DP_RADDR, DP_RDATA, DP_FETCH0, DP_FETCH1,
		DP_FETCH2, DP_EXEC, DP_FLAG, DP_LOOP, DP_FINISH
	} step_t;

	typedef enum logic [1:0] {
		EX_SINGLE,
		EX_FLAG,
		EX_LOOP
	} ex_kind_t;

	typedef struct packed {
		step_t step;
		logic  accept;
		logic  out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic     clear_done;
		logic     halted;
		ex_kind_t kind;
		logic     loop_last;
	} dp_status_t;

	localparam logic [7:0] FONT [FONT_BYTES] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	function automatic logic [7:0] font_byte(input logic [MEM_AW-1:0] a);
		logic [7:0] b;
		b = 8'h00;
		if (a < MEM_AW'(FONT_BYTES))
			b = FONT[a[6:0]];
		return b;
	endfunction

endpackage

// ===== hw/rtl/chip8_instruction_executor_unit.sv =====
// chip8_instruction_executor_unit: top level of the chip8 executor
// depends on c8ie_pkg, c8ie_ctrl and c8ie_dp
//
// After reset the unit initializes its 4 KiB memory (hex font at 0..79,
// zero elsewhere) and the sixteen V registers; in_ready stays low
// meanwhile, configuration writes are taken. A load beat runs LOAD and
// FINISH, a read RADDR, RDATA and FINISH, an exec beat FETCH0..FETCH2,
// EXEC and FINISH (two fetch reads and a register-file read through single
// ports), plus FLAG when VF is also written or LOOP for FX55/FX65/FX33,
// which move one byte per cycle through the memory port. A finished result
// waits in the output register while the next beat is taken.

module chip8_instruction_executor_unit import c8ie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [11:0] address,
	input  logic [7:0]  data,
	input  logic [7:0]  random_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        halted,
	output logic [11:0] program_counter,
	output logic        clear_screen,
	output logic        draw_request,
	output logic [7:0]  draw_x,
	output logic [7:0]  draw_y,
	output logic [3:0]  draw_rows,
	output logic [15:0] draw_address,
	output logic        sound_on,
	output logic [7:0]  read_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	c8ie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.action    (action),
		.out_ready (out_ready),
		.status    (status),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	c8ie_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.address         (address),
		.data            (data),
		.random_byte     (random_byte),
		.halted          (halted),
		.program_counter (program_counter),
		.clear_screen    (clear_screen),
		.draw_request    (draw_request),
		.draw_x          (draw_x),
		.draw_y          (draw_y),
		.draw_rows       (draw_rows),
		.draw_address    (draw_address),
		.sound_on        (sound_on),
		.read_data       (read_data)
	);

endmodule

// ===== hw/rtl/c8ie_ctrl.sv =====
// c8ie_ctrl: sequencing state machine of the chip8 executor
// depends on c8ie_pkg

module c8ie_ctrl import c8ie_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] action,
	input  logic       out_ready,
	input  dp_status_t status,
	output logic       in_ready,
	output logic       out_valid,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd.step     = DP_IDLE;
		cmd.accept   = 1'b0;
		cmd.out_load = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.step = DP_CLEAR;
				if (status.clear_done)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (action_t'(action))
						ACT_LOAD: state_d = ST_LOAD;
						ACT_READ: state_d = ST_RADDR;
						ACT_EXEC: state_d = status.halted ? ST_FINISH : ST_FETCH0;
						default:  state_d = ST_FINISH;
					endcase
				end
			end
			ST_LOAD: begin
				cmd.step = DP_LOAD;
				state_d  = ST_FINISH;
			end
			ST_RADDR: begin
				cmd.step = DP_RADDR;
				state_d  = ST_RDATA;
			end
			ST_RDATA: begin
				cmd.step = DP_RDATA;
				state_d  = ST_FINISH;
			end
			ST_FETCH0: begin
				cmd.step = DP_FETCH0;
				state_d  = ST_FETCH1;
			end
			ST_FETCH1: begin
				cmd.step = DP_FETCH1;
				state_d  = ST_FETCH2;
			end
			ST_FETCH2: begin
				cmd.step = DP_FETCH2;
				state_d  = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.step = DP_EXEC;
				unique case (status.kind)
					EX_FLAG: state_d = ST_FLAG;
					EX_LOOP: state_d = ST_LOOP;
					default: state_d = ST_FINISH;
				endcase
			end
			ST_FLAG: begin
				cmd.step = DP_FLAG;
				state_d  = ST_FINISH;
			end
			ST_LOOP: begin
				cmd.step = DP_LOOP;
				if (status.loop_last)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.step = DP_FINISH;
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

endmodule

// ===== hw/rtl/c8ie_dp.sv =====
// c8ie_dp: datapath of the chip8 executor: memory, register file, stack,
// timers, instruction decode and the result register; depends on c8ie_pkg

module c8ie_dp import c8ie_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,
	input  logic [11:0] address,
	input  logic [7:0]  data,
	input  logic [7:0]  random_byte,
	output logic        halted,
	output logic [11:0] program_counter,
	output logic        clear_screen,
	output logic        draw_request,
	output logic [7:0]  draw_x,
	output logic [7:0]  draw_y,
	output logic [3:0]  draw_rows,
	output logic [15:0] draw_address,
	output logic        sound_on,
	output logic [7:0]  read_data
);

	localparam logic [3:0] OP_SYS  = 4'h0, OP_JP   = 4'h1, OP_CALL = 4'h2, OP_SEQ  = 4'h3;
	localparam logic [3:0] OP_SNE  = 4'h4, OP_SEQV = 4'h5, OP_LD   = 4'h6, OP_ADD  = 4'h7;
	localparam logic [3:0] OP_ALU  = 4'h8, OP_SNEV = 4'h9, OP_LDI  = 4'hA, OP_JPV  = 4'hB;
	localparam logic [3:0] OP_RND  = 4'hC, OP_DRW  = 4'hD, OP_KEY  = 4'hE, OP_MISC = 4'hF;
	localparam logic [15:0] OP_CLS = 16'h00E0, OP_RET = 16'h00EE;
	localparam logic [3:0] ALU_MOV = 4'h0, ALU_AND = 4'h2, ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4, ALU_SUB = 4'h5;
	localparam logic [7:0] KEY_DOWN = 8'h9E, KEY_UP = 8'hA1;
	localparam logic [7:0] F_GDT = 8'h07, F_SDT = 8'h15, F_SST = 8'h18, F_ADDI = 8'h1E;
	localparam logic [7:0] F_FONT = 8'h29, F_BCD = 8'h33, F_STORE = 8'h55, F_LOAD = 8'h65;
	localparam logic [3:0] VF = 4'hF;

	logic [7:0]        mem [MEMORY_DEPTH];
	logic              mem_we;
	logic [MEM_AW-1:0] mem_wa, mem_ra, clr_q;
	logic [7:0]        mem_wd, rdata_q;

	logic [7:0]  v_rf [16];
	logic        rf_we;
	logic [3:0]  rf_wa, ra_a, ra_b;
	logic [7:0]  rf_wd, vx_q, vy_q;

	logic [11:0] stack_q [STACK_DEPTH];
	logic [SP_W-1:0] sp_q, sp_dec;

	logic [11:0] addr_q, pc_q, pc_n, pc_adv, pc_inc1;
	logic [7:0]  data_q, rnd_q, op_hi_q;
	logic [15:0] op_q, idx_q, idx_n, lp_addr, rd_addr;
	logic [7:0]  delay_q, sound_q, tick_q, tdiv_q, tick_inc, dly_set, snd_set;
	logic        halt_q, flag_q, tick_hit;
	logic [3:0]  cnt_q, x, n;
	logic [7:0]  nn;
	logic [3:0]  bcd_q [3];
	logic        clr_req_q, draw_q;
	logic [7:0]  dx_q, dy_q, rd_q;
	logic [3:0]  drows_q;
	logic [15:0] daddr_q;

	logic        ex_we, bad, skip, push, flag_n, clr_req, draw_req;
	logic [7:0]  ex_wd;
	ex_kind_t    kind;
	logic [8:0]  sum9;
	logic [16:0] sum17;
	logic [1:0]  hund;
	logic [6:0]  rem;
	logic [14:0] tprod;
	logic [3:0]  tens, ones;

	assign x       = op_q[11:8];
	assign n       = op_q[3:0];
	assign nn      = op_q[7:0];
	assign pc_adv  = pc_q + 12'd2;
	assign pc_inc1 = pc_q + 12'd1;
	assign sp_dec  = sp_q - SP_W'(1);
	assign lp_addr = idx_q + {12'b0, cnt_q};
	assign rd_addr = lp_addr + 16'd1;

	// bcd digits of vx
	always_comb begin
		if (vx_q >= 8'd200)
			hund = 2'd2;
		else if (vx_q >= 8'd100)
			hund = 2'd1;
		else
			hund = 2'd0;
		case (hund)
			2'd2:    rem = 7'(vx_q - 8'd200);
			2'd1:    rem = 7'(vx_q - 8'd100);
			default: rem = vx_q[6:0];
		endcase
		tprod = 15'({8'b0, rem} * 15'd205);
		tens  = tprod[14:11];
		ones  = 4'(rem - 7'({tens, 3'b000} + {2'b00, tens, 1'b0}));
	end

	// instruction decode
	always_comb begin
		ex_we    = 1'b0;
		ex_wd    = vx_q;
		pc_n     = pc_adv;
		idx_n    = idx_q;
		push     = 1'b0;
		bad      = 1'b0;
		skip     = 1'b0;
		kind     = EX_SINGLE;
		flag_n   = 1'b0;
		clr_req  = 1'b0;
		draw_req = 1'b0;
		dly_set  = delay_q;
		snd_set  = sound_q;
		sum9     = {1'b0, vx_q} + {1'b0, vy_q};
		sum17    = {1'b0, idx_q} + {9'b0, vx_q};
		unique case (op_q[15:12])
			OP_SYS: begin
				if (op_q == OP_CLS)
					clr_req = 1'b1;
				else if (op_q == OP_RET)
					pc_n = stack_q[sp_dec];
				else
					bad = 1'b1;
			end
			OP_JP:   pc_n = op_q[11:0];
			OP_CALL: begin
				push = 1'b1;
				pc_n = op_q[11:0];
			end
			OP_SEQ:  skip = (vx_q == nn);
			OP_SNE:  skip = (vx_q != nn);
			OP_SEQV: skip = (vx_q == vy_q);
			OP_LD: begin
				ex_we = 1'b1;
				ex_wd = nn;
			end
			OP_ADD: begin
				ex_we = 1'b1;
				ex_wd = vx_q + nn;
			end
			OP_ALU: begin
				unique case (n)
					ALU_MOV: begin
						ex_we = 1'b1;
						ex_wd = vy_q;
					end
					ALU_AND: begin
						ex_we = 1'b1;
						ex_wd = vx_q & vy_q;
					end
					ALU_XOR: begin
						ex_we = 1'b1;
						ex_wd = vx_q ^ vy_q;
					end
					ALU_ADD: begin
						ex_we  = 1'b1;
						ex_wd  = sum9[7:0];
						flag_n = sum9[8];
						kind   = EX_FLAG;
					end
					ALU_SUB: begin
						ex_we  = 1'b1;
						ex_wd  = vx_q - vy_q;
						flag_n = (vx_q >= vy_q);
						kind   = EX_FLAG;
					end
					default: bad = 1'b1;
				endcase
			end
			OP_SNEV: skip = (vx_q != vy_q);
			OP_LDI:  idx_n = {4'b0, op_q[11:0]};
			OP_JPV:  bad = 1'b1;
			OP_RND: begin
				ex_we = 1'b1;
				ex_wd = rnd_q & nn;
			end
			OP_DRW:  draw_req = 1'b1;
			OP_KEY: begin
				if (nn == KEY_UP)
					skip = 1'b1;
				else if (nn != KEY_DOWN)
					bad = 1'b1;
			end
			OP_MISC: begin
				unique case (nn)
					F_GDT: begin
						ex_we = 1'b1;
						ex_wd = delay_q;
					end
					F_SDT: dly_set = vx_q;
					F_SST: snd_set = vx_q;
					F_ADDI: begin
						flag_n = (sum17 > 17'hFFF);
						idx_n  = sum17[15:0];
						kind   = EX_FLAG;
					end
					F_FONT:  idx_n = {6'b0, vx_q, 2'b00} + {8'b0, vx_q};
					F_BCD:   kind = EX_LOOP;
					F_STORE: kind = EX_LOOP;
					F_LOAD:  kind = EX_LOOP;
					default: bad = 1'b1;
				endcase
			end
			default: bad = 1'b1;
		endcase
		if (skip)
			pc_n = pc_q + 12'd4;
	end

	assign tick_inc = tick_q + 8'd1;
	assign tick_hit = (tick_inc == tdiv_q);

	assign status.clear_done = (clr_q == MEM_AW'(MEMORY_DEPTH - 1));
	assign status.halted     = halt_q;
	assign status.kind       = kind;
	assign status.loop_last  = (nn == F_BCD) ? (cnt_q == 4'd2) : (cnt_q == x);

	// memory and register file port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q[MEM_AW-1:0];
		mem_wd = data_q;
		mem_ra = addr_q[MEM_AW-1:0];
		rf_we  = 1'b0;
		rf_wa  = x;
		rf_wd  = ex_wd;
		ra_a   = x;
		ra_b   = rdata_q[7:4];
		case (cmd.step)
			DP_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = font_byte(clr_q);
				rf_we  = 1'b1;
				rf_wa  = clr_q[3:0];
				rf_wd  = 8'h00;
			end
			DP_LOAD:   mem_we = 1'b1;
			DP_FETCH0: mem_ra = pc_q[MEM_AW-1:0];
			DP_FETCH1: mem_ra = pc_inc1[MEM_AW-1:0];
			DP_FETCH2: ra_a = op_hi_q[3:0];
			DP_EXEC: begin
				mem_ra = idx_q[MEM_AW-1:0];
				rf_we  = ex_we;
				ra_a   = 4'd0;
			end
			DP_FLAG: begin
				rf_we = 1'b1;
				rf_wa = VF;
				rf_wd = {7'b0, flag_q};
			end
			DP_LOOP: begin
				mem_wa = lp_addr[MEM_AW-1:0];
				mem_ra = rd_addr[MEM_AW-1:0];
				ra_a   = cnt_q + 4'd1;
				if (nn == F_LOAD) begin
					rf_we = 1'b1;
					rf_wa = cnt_q;
					rf_wd = rdata_q;
				end else begin
					mem_we = 1'b1;
					mem_wd = (nn == F_BCD) ? {4'b0, bcd_q[cnt_q[1:0]]} : vx_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (rf_we)
			v_rf[rf_wa] <= rf_wd;
		vx_q <= v_rf[ra_a];
		vy_q <= v_rf[ra_b];
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			pc_q    <= START_RESET;
			tdiv_q  <= TDIV_RESET;
			idx_q   <= 16'h0000;
			sp_q    <= '0;
			delay_q <= 8'h00;
			sound_q <= 8'h00;
			tick_q  <= 8'h00;
			halt_q  <= 1'b0;
			for (int i = 0; i < STACK_DEPTH; i++)
				stack_q[i] <= 12'h000;
		end else begin
			if (cmd.step == DP_CLEAR)
				clr_q <= clr_q + MEM_AW'(1);
			if (cfg_we) begin
				if (cfg_index == CFG_START)
					pc_q <= cfg_data;
				else
					tdiv_q <= cfg_data[7:0];
			end
			if (cmd.step == DP_EXEC) begin
				pc_q  <= pc_n;
				idx_q <= idx_n;
				if (push) begin
					stack_q[sp_q] <= pc_adv;
					sp_q          <= sp_q + SP_W'(1);
				end else if (op_q == OP_RET) begin
					sp_q <= sp_dec;
				end
				if (bad)
					halt_q <= 1'b1;
				tick_q  <= tick_hit ? 8'h00 : tick_inc;
				delay_q <= (tick_hit && dly_set != 8'h00) ? dly_set - 8'd1 : dly_set;
				sound_q <= (tick_hit && snd_set != 8'h00) ? snd_set - 8'd1 : snd_set;
			end
			if (cmd.step == DP_LOOP && status.loop_last && nn != F_BCD)
				idx_q <= idx_q + {12'b0, x} + 16'd1;
		end
	end

	// per-beat working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q    <= address;
			data_q    <= data;
			rnd_q     <= random_byte;
			clr_req_q <= 1'b0;
			draw_q    <= 1'b0;
			dx_q      <= 8'h00;
			dy_q      <= 8'h00;
			drows_q   <= 4'h0;
			daddr_q   <= 16'h0000;
			rd_q      <= 8'h00;
		end
		if (cmd.step == DP_RDATA)
			rd_q <= rdata_q;
		if (cmd.step == DP_FETCH1)
			op_hi_q <= rdata_q;
		if (cmd.step == DP_FETCH2)
			op_q <= {op_hi_q, rdata_q};
		if (cmd.step == DP_EXEC) begin
			flag_q    <= flag_n;
			cnt_q     <= 4'd0;
			bcd_q[0]  <= {2'b00, hund};
			bcd_q[1]  <= tens;
			bcd_q[2]  <= ones;
			clr_req_q <= clr_req;
			if (draw_req) begin
				draw_q  <= 1'b1;
				dx_q    <= vx_q;
				dy_q    <= vy_q;
				drows_q <= n;
				daddr_q <= idx_q;
			end
		end
		if (cmd.step == DP_LOOP)
			cnt_q <= cnt_q + 4'd1;
		if (cmd.out_load) begin
			halted          <= halt_q;
			program_counter <= pc_q;
			clear_screen    <= clr_req_q;
			draw_request    <= draw_q;
			draw_x          <= dx_q;
			draw_y          <= dy_q;
			draw_rows       <= drows_q;
			draw_address    <= daddr_q;
			sound_on        <= (sound_q != 8'h00);
			read_data       <= rd_q;
		end
	end

endmodule

// ===== verif/tb_chip8_instruction_executor_unit.sv =====
// tb_chip8_instruction_executor_unit: self-checking bench for the chip8 executor
// depends on c8ie_pkg and chip8_instruction_executor_unit; a shadow model plans
// programs ahead of the driver and a second copy predicts each result beat
`timescale 1ns / 1ps

module tb_chip8_instruction_executor_unit import c8ie_pkg::*;;

	localparam int IDLE_LIMIT = 30000;

	typedef struct packed {
		logic [1:0]  act;
		logic [11:0] addr;
		logic [7:0]  data;
		logic [7:0]  rnd;
	} cmd_beat_t;

	typedef struct packed {
		logic        halted;
		logic [11:0] pc;
		logic        clr;
		logic        drw;
		logic [7:0]  dx;
		logic [7:0]  dy;
		logic [3:0]  rows;
		logic [15:0] daddr;
		logic        snd;
		logic [7:0]  rd;
	} status_beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [11:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [11:0] address;
	logic [7:0]  data;
	logic [7:0]  random_byte;
	logic        out_valid;
	logic        out_ready;
	logic        halted;
	logic [11:0] program_counter;
	logic        clear_screen;
	logic        draw_request;
	logic [7:0]  draw_x;
	logic [7:0]  draw_y;
	logic [3:0]  draw_rows;
	logic [15:0] draw_address;
	logic        sound_on;
	logic [7:0]  read_data;

	chip8_instruction_executor_unit u_dut (.*);

	// copy 0 plans stimulus, copy 1 tracks accepted beats
	logic [7:0]  cpu_mem   [2][MEMORY_DEPTH];
	logic [7:0]  cpu_v     [2][16];
	logic [11:0] cpu_stack [2][STACK_DEPTH];
	logic [3:0]  cpu_sp    [2];
	logic [11:0] cpu_pc    [2];
	logic [15:0] cpu_i     [2];
	logic [7:0]  cpu_delay [2];
	logic [7:0]  cpu_sound [2];
	logic [7:0]  cpu_tick  [2];
	logic        cpu_halt  [2];
	logic [7:0]  cpu_tdiv  [2];

	cmd_beat_t    cmd_q[$];
	status_beat_t status_q[$];
	cmd_beat_t    cur_cmd;
	int           errors;
	int           burst_left;
	int           gap_left;
	int           beats_seen;
	int           hold_left;
	bit           hold_done;
	int           rcv_mode;
	int           rcv_cnt;
	int           idle_cycles;

	function automatic void cpu_init(int s);
		for (int a = 0; a < MEMORY_DEPTH; a++)
			cpu_mem[s][a] = (a < FONT_BYTES) ? FONT[a] : 8'h00;
		for (int r = 0; r < 16; r++)
			cpu_v[s][r] = 8'h00;
		for (int r = 0; r < STACK_DEPTH; r++)
			cpu_stack[s][r] = 12'h000;
		cpu_sp[s]    = '0;
		cpu_pc[s]    = START_RESET;
		cpu_tdiv[s]  = TDIV_RESET;
		cpu_i[s]     = '0;
		cpu_delay[s] = '0;
		cpu_sound[s] = '0;
		cpu_tick[s]  = '0;
		cpu_halt[s]  = 1'b0;
	endfunction

	function automatic bit op_undefined(logic [15:0] op);
		bit bad;
		bad = 1'b0;
		case (op[15:12])
			4'h0: bad = !(op == 16'h00E0 || op == 16'h00EE);
			4'h8: bad = !(op[3:0] inside {4'h0, 4'h2, 4'h3, 4'h4, 4'h5});
			4'hB: bad = 1'b1;
			4'hE: bad = !(op[7:0] == 8'h9E || op[7:0] == 8'hA1);
			4'hF: bad = !(op[7:0] inside {8'h07, 8'h15, 8'h18, 8'h1E, 8'h29,
				8'h33, 8'h55, 8'h65});
			default: bad = 1'b0;
		endcase
		return bad;
	endfunction

	function automatic logic [15:0] op_at_pc(int s);
		return {cpu_mem[s][cpu_pc[s]], cpu_mem[s][cpu_pc[s] + 12'd1]};
	endfunction

	function automatic void cpu_exec(int s, logic [7:0] rnd, inout status_beat_t o);
		logic [15:0] op;
		logic [3:0]  x, y;
		logic [7:0]  vx, vy, nn;
		logic [8:0]  sum;
		logic [16:0] isum;
		bit          skip;
		op   = op_at_pc(s);
		x    = op[11:8];
		y    = op[7:4];
		nn   = op[7:0];
		vx   = cpu_v[s][x];
		vy   = cpu_v[s][y];
		skip = 1'b0;
		cpu_pc[s] = cpu_pc[s] + 12'd2;
		if (op_undefined(op)) begin
			cpu_halt[s] = 1'b1;
		end else begin
			case (op[15:12])
				4'h0: begin
					if (op == 16'h00E0) begin
						o.clr = 1'b1;
					end else begin
						cpu_sp[s] = cpu_sp[s] - 4'd1;
						cpu_pc[s] = cpu_stack[s][cpu_sp[s]];
					end
				end
				4'h1: cpu_pc[s] = op[11:0];
				4'h2: begin
					cpu_stack[s][cpu_sp[s]] = cpu_pc[s];
					cpu_sp[s] = cpu_sp[s] + 4'd1;
					cpu_pc[s] = op[11:0];
				end
				4'h3: skip = (vx == nn);
				4'h4: skip = (vx != nn);
				4'h5: skip = (vx == vy);
				4'h6: cpu_v[s][x] = nn;
				4'h7: cpu_v[s][x] = vx + nn;
				4'h8: begin
					case (op[3:0])
						4'h0: cpu_v[s][x] = vy;
						4'h2: cpu_v[s][x] = vx & vy;
						4'h3: cpu_v[s][x] = vx ^ vy;
						4'h4: begin
							sum = {1'b0, vx} + {1'b0, vy};
							cpu_v[s][x]  = sum[7:0];
							cpu_v[s][15] = {7'd0, sum[8]};
						end
						default: begin
							cpu_v[s][x]  = vx - vy;
							cpu_v[s][15] = (vx >= vy) ? 8'd1 : 8'd0;
						end
					endcase
				end
				4'h9: skip = (vx != vy);
				4'hA: cpu_i[s] = {4'h0, op[11:0]};
				4'hC: cpu_v[s][x] = rnd & nn;
				4'hD: begin
					o.drw   = 1'b1;
					o.dx    = vx;
					o.dy    = vy;
					o.rows  = op[3:0];
					o.daddr = cpu_i[s];
				end
				4'hE: skip = (nn == 8'hA1);
				default: begin
					case (nn)
						8'h07: cpu_v[s][x] = cpu_delay[s];
						8'h15: cpu_delay[s] = vx;
						8'h18: cpu_sound[s] = vx;
						8'h1E: begin
							isum = {1'b0, cpu_i[s]} + {9'd0, vx};
							cpu_v[s][15] = (isum > 17'h0FFF) ? 8'd1 : 8'd0;
							cpu_i[s] = isum[15:0];
						end
						8'h29: cpu_i[s] = vx * 16'd5;
						8'h33: begin
							cpu_mem[s][cpu_i[s][11:0]]         = 8'(vx / 8'd100);
							cpu_mem[s][cpu_i[s][11:0] + 12'd1] = 8'((vx / 8'd10) % 8'd10);
							cpu_mem[s][cpu_i[s][11:0] + 12'd2] = 8'(vx % 8'd10);
						end
						8'h55: begin
							for (int k = 0; k <= x; k++)
								cpu_mem[s][cpu_i[s][11:0] + 12'(k)] = cpu_v[s][k];
							cpu_i[s] = cpu_i[s] + x + 16'd1;
						end
						default: begin
							for (int k = 0; k <= x; k++)
								cpu_v[s][k] = cpu_mem[s][cpu_i[s][11:0] + 12'(k)];
							cpu_i[s] = cpu_i[s] + x + 16'd1;
						end
					endcase
				end
			endcase
		end
		if (skip)
			cpu_pc[s] = cpu_pc[s] + 12'd2;
		cpu_tick[s] = cpu_tick[s] + 8'd1;
		if (cpu_tick[s] == cpu_tdiv[s]) begin
			cpu_tick[s] = '0;
			if (cpu_sound[s] != 0)
				cpu_sound[s] = cpu_sound[s] - 8'd1;
			if (cpu_delay[s] != 0)
				cpu_delay[s] = cpu_delay[s] - 8'd1;
		end
	endfunction

	function automatic status_beat_t cpu_step(int s, cmd_beat_t c);
		status_beat_t o;
		o = '0;
		if (c.act == ACT_LOAD)
			cpu_mem[s][c.addr] = c.data;
		else if (c.act == ACT_READ)
			o.rd = cpu_mem[s][c.addr];
		else if (c.act == ACT_EXEC && !cpu_halt[s])
			cpu_exec(s, c.rnd, o);
		o.halted = cpu_halt[s];
		o.pc     = cpu_pc[s];
		o.snd    = (cpu_sound[s] != 0);
		return o;
	endfunction

	function automatic logic [15:0] rand_opcode();
		logic [3:0]  x, y, n;
		logic [7:0]  nn;
		logic [15:0] op;
		x  = 4'($urandom_range(0, 15));
		y  = 4'($urandom_range(0, 15));
		n  = 4'($urandom_range(0, 15));
		nn = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 3) == 0)
			x = 4'($urandom_range(0, 3));
		case ($urandom_range(0, 29))
			0:  op = 16'h00E0;
			1:  op = 16'h00EE;
			2:  op = {4'h1, y, nn};
			3:  op = {4'h2, y, nn};
			4:  op = {4'h3, x, nn};
			5:  op = {4'h4, x, nn};
			6:  op = {4'h5, x, y, n};
			7, 8: op = {4'h6, x, nn};
			9:  op = {4'h7, x, nn};
			10: op = {4'h8, x, y, 4'h0};
			11: op = {4'h8, x, y, 4'h2};
			12: op = {4'h8, x, y, 4'h3};
			13: op = {4'h8, x, y, 4'h4};
			14: op = {4'h8, x, y, 4'h5};
			15: op = {4'h9, x, y, n};
			16: op = {4'hA, y, nn};
			17: op = {4'hC, x, nn};
			18: op = {4'hD, x, y, n};
			19: op = {4'hE, x, 8'h9E};
			20: op = {4'hE, x, 8'hA1};
			21: op = {4'hF, x, 8'h07};
			22: op = {4'hF, x, 8'h15};
			23: op = {4'hF, x, 8'h18};
			24: op = {4'hF, x, 8'h1E};
			25: op = {4'hF, x, 8'h29};
			26: op = {4'hF, x, 8'h33};
			27: op = {4'hF, x, 8'h55};
			default: op = {4'hF, x, 8'h65};
		endcase
		return op;
	endfunction

	task automatic add_beat(logic [1:0] act, logic [11:0] addr, logic [7:0] d,
			logic [7:0] rnd);
		cmd_beat_t c;
		c = '{act: act, addr: addr, data: d, rnd: rnd};
		void'(cpu_step(0, c));
		cmd_q.push_back(c);
	endtask

	task automatic add_rand_beat(logic [1:0] act);
		add_beat(act, 12'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// place an opcode at the planned pc, then run it
	task automatic add_op(logic [15:0] op);
		logic [11:0] pc0;
		pc0 = cpu_pc[0];
		add_beat(ACT_LOAD, pc0, op[15:8], 8'($urandom));
		add_beat(ACT_LOAD, pc0 + 12'd1, op[7:0], 8'($urandom));
		add_rand_beat(ACT_EXEC);
	endtask

	task automatic add_random(int count);
		int r;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 72)
				add_op(rand_opcode());
			else if (r < 84 && !op_undefined(op_at_pc(0)))
				add_rand_beat(ACT_EXEC);
			else if (r < 92)
				add_rand_beat(ACT_LOAD);
			else if (r < 98)
				add_rand_beat(ACT_READ);
			else
				add_rand_beat(ACT_NONE);
		end
	endtask

	task automatic drain();
		while (cmd_q.size() != 0 || status_q.size() != 0 || in_valid)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [11:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		for (int s = 0; s < 2; s++) begin
			if (idx == CFG_START) begin
				cpu_pc[s] = val;
			end else begin
				cpu_tdiv[s] = val[7:0];
			end
		end
	endtask

	task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
		if (exp_v !== got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name,
				exp_v, got_v);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// driver: bursts of beats with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (in_valid && in_ready)
				status_q.push_back(cpu_step(1, cur_cmd));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (cmd_q.size() != 0) begin
					cur_cmd     = cmd_q.pop_front();
					action      <= cur_cmd.act;
					address     <= cur_cmd.addr;
					data        <= cur_cmd.data;
					random_byte <= cur_cmd.rnd;
					in_valid    <= 1'b1;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(0, 40);
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
			rcv_mode  <= 0;
			rcv_cnt   <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && beats_seen == 300) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			out_ready <= 1'b0;
		end else begin
			rcv_cnt <= rcv_cnt + 1;
			if (rcv_cnt % 64 == 0)
				rcv_mode <= $urandom_range(0, 2);
			case (rcv_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 1);
				default: out_ready <= (rcv_cnt % 16) < 5;
			endcase
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		status_beat_t e;
		if (!arst_n) begin
			beats_seen <= 0;
		end else if (out_valid && out_ready) begin
			beats_seen <= beats_seen + 1;
			if (status_q.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, actual pc %h", $realtime,
					program_counter);
			end else begin
				e = status_q.pop_front();
				check_field("halted", 16'(e.halted), 16'(halted));
				check_field("program_counter", 16'(e.pc), 16'(program_counter));
				check_field("clear_screen", 16'(e.clr), 16'(clear_screen));
				check_field("draw_request", 16'(e.drw), 16'(draw_request));
				check_field("draw_x", 16'(e.dx), 16'(draw_x));
				check_field("draw_y", 16'(e.dy), 16'(draw_y));
				check_field("draw_rows", 16'(e.rows), 16'(draw_rows));
				check_field("draw_address", e.daddr, draw_address);
				check_field("sound_on", 16'(e.snd), 16'(sound_on));
				check_field("read_data", 16'(e.rd), 16'(read_data));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [15:0] bad_op;
		errors      = 0;
		idle_cycles = 0;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_START;
		cfg_data    = '0;
		in_valid    = 1'b0;
		out_ready   = 1'b0;
		action      = ACT_LOAD;
		address     = '0;
		data        = '0;
		random_byte = '0;
		cpu_init(0);
		cpu_init(1);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes and the flag corner cases
		add_beat(ACT_READ, 12'h000, 8'h00, 8'h00);
		add_beat(ACT_LOAD, 12'hFFF, 8'hFF, 8'hFF);
		add_beat(ACT_READ, 12'hFFF, 8'h00, 8'h00);
		add_beat(ACT_NONE, 12'hABC, 8'h55, 8'hAA);
		add_op(16'h6AFF);
		add_op(16'h8AA4);
		add_op(16'h8A05);
		add_op(16'h6F10);
		add_op(16'hFF18);
		add_op(16'hAFFF);
		add_op(16'hFA1E);
		add_op(16'h1FFE);
		add_op(16'hFF65);
		drain();

		write_reg(CFG_START, 12'h000);
		write_reg(CFG_TDIV, 12'd1);
		add_random(260);
		write_reg(CFG_START, 12'hFFF);
		write_reg(CFG_TDIV, 12'd255);
		add_random(260);
		write_reg(CFG_START, 12'($urandom_range(0, 4095)));
		write_reg(CFG_TDIV, 12'($urandom_range(1, 255)));
		add_random(230);

		// undefined opcode halts for good; loads and reads still work
		do
			bad_op = 16'($urandom);
		while (!op_undefined(bad_op));
		add_op(bad_op);
		add_rand_beat(ACT_EXEC);
		add_rand_beat(ACT_LOAD);
		add_rand_beat(ACT_READ);
		add_rand_beat(ACT_EXEC);
		drain();
		repeat (30) @(posedge clk);
		if (errors == 0 && status_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/c8ie_pkg.sv
hw/rtl/c8ie_ctrl.sv
hw/rtl/c8ie_dp.sv
hw/rtl/chip8_instruction_executor_unit.sv
verif/tb_chip8_instruction_executor_unit.sv
